/* hdl/ffba_pkg.sv */
// Shared constants, codes and types of the first-fit block allocator.
package ffba_pkg;

    localparam int ARENA_BYTES  = 8192;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 64;

    localparam int FIELD_W = 13;
    localparam int AW      = $clog2(ARENA_BYTES + 1);
    localparam int XW      = (AW > FIELD_W) ? AW : FIELD_W;
    localparam int IW      = $clog2(MAX_BLOCKS);
    localparam int CW      = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [XW-1:0] HDR = XW'(HEADER_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SPLIT,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [XW-1:0] addr;
        logic [XW-1:0] len;
        logic          used;
    } entry_t;

    typedef struct packed {
        logic          shift;
        logic          app;
        logic [IW-1:0] sel;
        entry_t        tail;
    } ctl_t;

    localparam entry_t RESET_ENTRY = '{
        addr: XW'(HEADER_BYTES),
        len:  XW'(ARENA_BYTES - HEADER_BYTES),
        used: 1'b0
    };

endpackage

/* hdl/ffba_cell.sv */
// One block table cell: holds an entry, takes its right neighbour or the tail on command.
module ffba_cell
    import ffba_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [IW-1:0] idx,
    input  ctl_t          ctl,
    input  entry_t        right,
    output entry_t        q
);

    entry_t q_reg;
    entry_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctl.shift)
        begin
            q_next = (idx == ctl.sel) ? ctl.tail : right;
        end
        else if (ctl.app && (idx == ctl.sel))
        begin
            q_next = ctl.tail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= RESET_ENTRY;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* hdl/ffba_ctrl.sv */
// Sequencer: walks the rotating cell row, splits, merges and keeps the free total.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         kind,
    input  logic [FIELD_W-1:0] alloc_size,
    input  logic [FIELD_W-1:0] free_address,
    input  entry_t             head,
    output ctl_t               ctl,
    output logic               busy,
    output logic               done,
    output logic [1:0]         status,
    output logic [FIELD_W-1:0] data_address,
    output logic [FIELD_W-1:0] free_bytes
);

    state_t        state_reg, state_next;
    logic [1:0]    kind_reg, kind_next;
    logic [XW-1:0] size_reg, size_next;
    logic [XW-1:0] faddr_reg, faddr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] left_reg, left_next;
    logic          found_reg, found_next;
    entry_t        tail_reg, tail_next;
    logic          tail_vld_reg, tail_vld_next;
    entry_t        rem_reg, rem_next;
    logic [XW-1:0] free_reg, free_next;
    logic [XW-1:0] addr_out_reg, addr_out_next;

    entry_t        x2;
    logic          fit;
    logic          split;
    logic          match;
    logic          mrg;
    logic [XW-1:0] rest;
    logic [XW-1:0] gain;
    logic [CW-1:0] nl;
    logic [CW-1:0] sel_w;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        size_next     = size_reg;
        faddr_next    = faddr_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        found_next    = found_reg;
        tail_next     = tail_reg;
        tail_vld_next = tail_vld_reg;
        rem_next      = rem_reg;
        free_next     = free_reg;
        addr_out_next = addr_out_reg;
        ctl           = '0;
        done          = 1'b0;

        fit   = (kind_reg == KIND_ALLOC) && !found_reg && !head.used && (head.len > size_reg);
        rest  = head.len - size_reg;
        split = fit && (rest > HDR) && (count_reg < CW'(MAX_BLOCKS));
        match = (kind_reg == KIND_FREE) && !found_reg && (head.addr == faddr_reg);

        x2 = head;
        if (fit)
        begin
            x2.used = 1'b1;
            if (split)
            begin
                x2.len = size_reg;
            end
        end
        if (match)
        begin
            x2.used = 1'b0;
        end

        mrg   = (kind_reg == KIND_FREE) && tail_vld_reg && !tail_reg.used && !x2.used;
        nl    = mrg ? (count_reg - CW'(1)) : count_reg;
        sel_w = nl - CW'(1);
        gain  = ((match && head.used) ? head.len : '0) + (mrg ? HDR : '0);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    size_next     = XW'(alloc_size);
                    faddr_next    = XW'(free_address);
                    found_next    = 1'b0;
                    tail_vld_next = 1'b0;
                    left_next     = count_reg;
                    if (kind == KIND_ALLOC)
                    begin
                        state_next = (XW'(alloc_size) > free_reg) ? S_REPLY : S_WALK;
                    end
                    else if (kind == KIND_FREE)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_WALK:
            begin
                ctl.shift = 1'b1;
                ctl.sel   = sel_w[IW-1:0];
                if (mrg)
                begin
                    ctl.tail     = tail_reg;
                    ctl.tail.len = tail_reg.len + x2.len + HDR;
                end
                else
                begin
                    ctl.tail = x2;
                end
                tail_next     = ctl.tail;
                tail_vld_next = 1'b1;
                count_next    = nl;
                found_next    = found_reg | fit | match;
                left_next     = left_reg - CW'(1);
                if (fit)
                begin
                    addr_out_next = head.addr;
                    free_next     = split ? (free_reg - size_reg - HDR) : (free_reg - head.len);
                end
                else
                begin
                    free_next = free_reg + gain;
                end
                rem_next.addr = head.addr + size_reg + HDR;
                rem_next.len  = rest - HDR;
                rem_next.used = 1'b0;
                if (split)
                begin
                    state_next = S_SPLIT;
                end
                else if (left_reg == CW'(1))
                begin
                    state_next = S_REPLY;
                end
            end
            S_SPLIT:
            begin
                ctl.app    = 1'b1;
                ctl.sel    = count_reg[IW-1:0];
                ctl.tail   = rem_reg;
                count_next = count_reg + CW'(1);
                state_next = (left_reg == '0) ? S_REPLY : S_WALK;
            end
            S_REPLY:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= CW'(1);
            left_reg     <= '0;
            found_reg    <= 1'b0;
            tail_vld_reg <= 1'b0;
            free_reg     <= XW'(ARENA_BYTES - HEADER_BYTES);
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            left_reg     <= left_next;
            found_reg    <= found_next;
            tail_vld_reg <= tail_vld_next;
            free_reg     <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        size_reg     <= size_next;
        faddr_reg    <= faddr_next;
        tail_reg     <= tail_next;
        rem_reg      <= rem_next;
        addr_out_reg <= addr_out_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        if (kind_reg == KIND_ALLOC)
        begin
            status = found_reg ? ST_OK : ST_NO_FIT;
        end
        else if (kind_reg == KIND_FREE)
        begin
            status = found_reg ? ST_OK : ST_NOT_FOUND;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign data_address = ((kind_reg == KIND_ALLOC) && found_reg) ?
                          addr_out_reg[FIELD_W-1:0] : '0;
    assign free_bytes   = free_reg[FIELD_W-1:0];

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken without going busy");

    a_app_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.app |-> $past(ctl.shift))
        else $error("append not preceded by a split shift");

    a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && mrg) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("merge did not drop the block count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (count_reg < CW'(MAX_BLOCKS)))
        else $error("split with a full table");
`endif

endmodule

/* hdl/first_fit_block_allocator_core.sv */
// Top level of the first-fit block allocator: cell row and sequencer.
//
//  channel   ports                                    handshake
//  request   kind, alloc_size, free_address           start high, busy low
//  result    status, data_address, free_bytes         done, one cycle
//
//  An item rotates the cell row once past the sequencer, one table entry per cycle,
//  with a split step between entries when a block is split; refused allocates and
//  queries skip the walk and go straight to the reply.
//  After reset the table holds one free block over the whole arena.
//  busy stays high until the done cycle is over; the receiver cannot stall.
module first_fit_block_allocator_core
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         kind,
    input  logic [FIELD_W-1:0] alloc_size,
    input  logic [FIELD_W-1:0] free_address,
    output logic               busy,
    output logic               done,
    output logic [1:0]         status,
    output logic [FIELD_W-1:0] data_address,
    output logic [FIELD_W-1:0] free_bytes
);

    ctl_t   ctl;
    entry_t cells_q [MAX_BLOCKS];

    genvar i;
    generate
        for (i = 0; i < MAX_BLOCKS; i++)
        begin : g_cell
            entry_t right;
            if (i == MAX_BLOCKS - 1)
            begin : g_last
                assign right = ctl.tail;
            end
            else
            begin : g_mid
                assign right = cells_q[i+1];
            end

            ffba_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .idx   (IW'(i)),
                .ctl   (ctl),
                .right (right),
                .q     (cells_q[i])
            );
        end
    endgenerate

    ffba_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .alloc_size   (alloc_size),
        .free_address (free_address),
        .head         (cells_q[0]),
        .ctl          (ctl),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .data_address (data_address),
        .free_bytes   (free_bytes)
    );

endmodule
